@@ hdl/erm_pkg.sv @@
`default_nettype none

package erm_pkg;

    localparam int ECHO_W      = 16;
    localparam int DIST_W      = 14;
    localparam int CFG_W       = 16;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // floor(w * 16 / 58) = floor(8w / 29), done as (8w * ceil(2^24 / 29)) >> 24
    localparam int                  RECIP_W     = 20;
    localparam logic [RECIP_W-1:0]  RECIP       = 20'd578525;
    localparam int                  RECIP_SHIFT = 24;
    localparam int                  SCALED_W    = ECHO_W + 3;
    localparam int                  PROD_W      = SCALED_W + RECIP_W;
    localparam int                  QUOT_W      = PROD_W - RECIP_SHIFT;

    localparam logic [DIST_W-1:0]   DIST_MAX       = 14'd16383;
    localparam logic [DIST_W-1:0]   HELD_RESET     = 14'd15984;
    localparam logic [CFG_W-1:0]    MIN_ECHO_RESET = 16'd116;
    localparam logic [CFG_W-1:0]    MAX_ECHO_RESET = 16'd23200;

    localparam logic REG_MIN_ECHO = 1'b0;
    localparam logic REG_MAX_ECHO = 1'b1;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic update;
        logic sort_en;
        logic sort_odd;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ hdl/erm_if.sv @@
`default_nettype none

interface erm_in_if;
    logic                       valid;
    logic                       ready;
    logic [erm_pkg::ECHO_W-1:0] echo_width;
    logic                       echo_seen;

    modport source (output valid, output echo_width, output echo_seen, input ready);
    modport sink   (input valid, input echo_width, input echo_seen, output ready);
endinterface

interface erm_out_if;
    logic                       valid;
    logic                       ready;
    logic [erm_pkg::DIST_W-1:0] median_distance;

    modport source (output valid, output median_distance, input ready);
    modport sink   (input valid, input median_distance, output ready);
endinterface

`default_nettype wire

@@ hdl/erm_dpath.sv @@
`default_nettype none

module erm_dpath #(
    parameter int WINDOW_LEN = 5
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire erm_pkg::t_dp_cmd           i_cmd,
    output erm_pkg::t_dp_sts                o_sts,
    input  wire logic [erm_pkg::ECHO_W-1:0] i_echo_width,
    input  wire logic                       i_echo_seen,
    input  wire logic [erm_pkg::CFG_W-1:0]  i_min_echo,
    input  wire logic [erm_pkg::CFG_W-1:0]  i_max_echo,
    output logic [erm_pkg::DIST_W-1:0]      o_median
);
    import erm_pkg::*;

    localparam int FILL_W = $clog2(WINDOW_LEN);
    localparam int MID    = WINDOW_LEN / 2;

    logic [ECHO_W-1:0] r_width;
    logic              r_seen;
    logic [PROD_W-1:0] r_prod;
    logic [DIST_W-1:0] r_held, n_held;
    logic [DIST_W-1:0] r_win [WINDOW_LEN];
    logic [DIST_W-1:0] n_sorted [WINDOW_LEN];
    logic [FILL_W-1:0] r_fill;
    logic [DIST_W-1:0] r_median;
    logic [QUOT_W-1:0] quot;
    logic [DIST_W-1:0] sat_dist;
    logic              in_range;

    assign quot     = r_prod[PROD_W-1:RECIP_SHIFT];
    assign sat_dist = (quot > QUOT_W'(DIST_MAX)) ? DIST_MAX : quot[DIST_W-1:0];
    assign in_range = r_seen && (r_width >= i_min_echo) && (r_width <= i_max_echo);
    assign n_held   = in_range ? sat_dist : r_held;

    // one odd-even transposition phase, disjoint pairs
    always_comb begin
        for (int i = 0; i < WINDOW_LEN; i++) begin
            n_sorted[i] = r_win[i];
        end
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
            if ((1'(i) == i_cmd.sort_odd) && (r_win[i] > r_win[i+1])) begin
                n_sorted[i]   = r_win[i+1];
                n_sorted[i+1] = r_win[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= HELD_RESET;
            r_fill <= '0;
        end else if (i_cmd.update) begin
            r_held <= n_held;
            r_fill <= (r_fill == FILL_W'(WINDOW_LEN - 1)) ? '0 : r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_width <= i_echo_width;
            r_seen  <= i_echo_seen;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'({r_width, 3'b000}) * PROD_W'(RECIP);
        end
        if (i_cmd.update) begin
            r_win[0] <= n_held;
            for (int i = 1; i < WINDOW_LEN; i++) begin
                r_win[i] <= r_win[i-1];
            end
        end else if (i_cmd.sort_en) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_win[i] <= n_sorted[i];
            end
        end
        if (i_cmd.load_out) begin
            r_median <= r_win[MID];
        end
    end

    assign o_sts.last = (r_fill == FILL_W'(WINDOW_LEN - 1));
    assign o_median   = r_median;

endmodule

`default_nettype wire

@@ hdl/erm_ctrl.sv @@
`default_nettype none

module erm_ctrl #(
    parameter int WINDOW_LEN = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire erm_pkg::t_dp_sts i_sts,
    output erm_pkg::t_dp_cmd      o_cmd
);
    import erm_pkg::*;

    localparam int PH_W = $clog2(WINDOW_LEN);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_UPD,
        S_SORT,
        S_EMIT
    } t_state;

    t_state            r_state, n_state;
    logic [PH_W-1:0]   r_phase, n_phase;
    logic              r_out_valid, n_out_valid;
    logic              slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state          = r_state;
        n_phase          = r_phase;
        o_cmd            = '0;
        o_cmd.sort_odd   = r_phase[0];
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_phase      = '0;
                n_state      = i_sts.last ? S_SORT : S_IDLE;
            end
            S_SORT: begin
                o_cmd.sort_en = 1'b1;
                if (r_phase == PH_W'(WINDOW_LEN - 1)) begin
                    n_state = S_EMIT;
                end else begin
                    n_phase = r_phase + 1'b1;
                end
            end
            S_EMIT: begin
                o_cmd.load_out = slot_free;
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ hdl/echo_range_median_filter.sv @@
`default_nettype none
// channel   dir  handshake      payload
// i_meas    in   valid/ready    echo_width[15:0], echo_seen
// o_med     out  valid/ready    median_distance[13:0]
// apb       in   psel/penable   paddr[2:0], pwdata[31:0], prdata[31:0]
//
// Each transaction steps through capture, reciprocal multiply and held/window
// update, one transaction at a time. Every WINDOW_LEN-th transaction adds
// WINDOW_LEN odd-even sort phases on the window registers plus an emit step.
// Output register lets the next transaction in while a median waits;
// emit stalls only if a second median is ready before the first is taken.
// Synchronous active-low reset: held distance 999 cm, limits 116/23200 us.

module echo_range_median_filter #(
    parameter int WINDOW_LEN = 5
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    erm_in_if.sink                              i_meas,
    erm_out_if.source                           o_med,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [erm_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [erm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [erm_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import erm_pkg::*;

    logic [CFG_W-1:0] r_min_echo;
    logic [CFG_W-1:0] r_max_echo;
    logic             cfg_wr;
    t_dp_cmd          cmd;
    t_dp_sts          sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_echo <= MIN_ECHO_RESET;
            r_max_echo <= MAX_ECHO_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_MIN_ECHO: r_min_echo <= pwdata[CFG_W-1:0];
                REG_MAX_ECHO: r_max_echo <= pwdata[CFG_W-1:0];
                default:      r_min_echo <= r_min_echo;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MIN_ECHO: prdata = APB_DATA_W'(r_min_echo);
            REG_MAX_ECHO: prdata = APB_DATA_W'(r_max_echo);
            default:      prdata = '0;
        endcase
    end

    erm_ctrl #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_meas.valid),
        .o_in_ready  (i_meas.ready),
        .o_out_valid (o_med.valid),
        .i_out_ready (o_med.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    erm_dpath #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_echo_width (i_meas.echo_width),
        .i_echo_seen  (i_meas.echo_seen),
        .i_min_echo   (r_min_echo),
        .i_max_echo   (r_max_echo),
        .o_median     (o_med.median_distance)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_meas.valid && i_meas.ready |=> !i_meas.ready)
        else $error("transaction accepted while previous one still in flight");

    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_med.valid || o_med.ready))
        else $error("median loaded over an untaken result");

    a_no_capture_in_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.load_in && (cmd.sort_en || cmd.update)))
        else $error("capture overlaps update or sort");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import erm_pkg::*;

    localparam int WIN            = 5;
    localparam int SETTLE_CYCLES  = 3 * WIN + 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RAND_PHASES    = 12;
    localparam int PHASE_ITEMS    = 150;

    typedef struct {
        logic [ECHO_W-1:0] width;
        logic              seen;
    } t_echo;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    erm_in_if  meas_if ();
    erm_out_if med_if ();

    echo_range_median_filter #(.WINDOW_LEN(WIN)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_meas  (meas_if),
        .o_med   (med_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // filter state as the block should hold it
    logic [CFG_W-1:0]  lim_min   = MIN_ECHO_RESET;
    logic [CFG_W-1:0]  lim_max   = MAX_ECHO_RESET;
    logic [DIST_W-1:0] held_dist = HELD_RESET;
    logic [DIST_W-1:0] win_dist [WIN];
    int                fill_cnt  = 0;
    logic [DIST_W-1:0] median_q [$];

    t_echo echo_q [$];
    int    n_queued    = 0;
    int    n_in        = 0;
    int    n_out       = 0;
    int    n_settings  = 0;
    int    fails       = 0;
    int    idle_cycles = 0;
    int    in_gap      = 0;
    int    out_stall   = 0;
    bit    in_idle_on  = 1'b0;
    bit    out_idle_on = 1'b0;
    bit    meas_fire   = 1'b0;
    bit    med_fire    = 1'b0;

    function automatic logic [DIST_W-1:0] echo_to_sixteenths(logic [ECHO_W-1:0] w);
        int unsigned d;
        d = (32'(w) * 32'd16) / 32'd58;
        return (d > 32'(DIST_MAX)) ? DIST_MAX : d[DIST_W-1:0];
    endfunction

    function automatic logic [DIST_W-1:0] window_median();
        logic [DIST_W-1:0] s [WIN];
        logic [DIST_W-1:0] t;
        for (int i = 0; i < WIN; i++) s[i] = win_dist[i];
        for (int i = 0; i < WIN - 1; i++) begin
            for (int j = 0; j < WIN - 1 - i; j++) begin
                if (s[j] > s[j+1]) begin
                    t = s[j]; s[j] = s[j+1]; s[j+1] = t;
                end
            end
        end
        return s[WIN/2];
    endfunction

    task automatic predict_echo(t_echo m);
        if (m.seen && m.width >= lim_min && m.width <= lim_max)
            held_dist = echo_to_sixteenths(m.width);
        win_dist[fill_cnt] = held_dist;
        fill_cnt++;
        if (fill_cnt == WIN) begin
            fill_cnt = 0;
            median_q.push_back(window_median());
        end
    endtask

    function automatic int pick_gap(bit on);
        int r;
        if (!on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sender
    always @(negedge i_clk) begin
        t_echo m;
        if (!i_rst_n) begin
            meas_if.valid <= 1'b0;
        end else if (!meas_if.valid || meas_fire) begin
            if (in_gap > 0) begin
                in_gap = in_gap - 1;
                meas_if.valid <= 1'b0;
            end else if (echo_q.size() != 0) begin
                m = echo_q.pop_front();
                meas_if.echo_width <= m.width;
                meas_if.echo_seen  <= m.seen;
                meas_if.valid      <= 1'b1;
                in_gap = pick_gap(in_idle_on);
            end else begin
                meas_if.valid <= 1'b0;
            end
        end
    end

    // receiver backpressure
    always @(negedge i_clk) begin
        if (out_stall > 0) begin
            out_stall = out_stall - 1;
            med_if.ready <= 1'b0;
        end else begin
            med_if.ready <= 1'b1;
            out_stall = pick_gap(out_idle_on);
        end
    end

    // monitor, checker, watchdog
    always @(posedge i_clk) begin
        t_echo             m;
        logic [DIST_W-1:0] want;
        meas_fire = i_rst_n && meas_if.valid && meas_if.ready;
        med_fire  = i_rst_n && med_if.valid && med_if.ready;
        if (med_fire) begin
            n_out++;
            if (median_q.size() == 0) begin
                fails++;
                if (fails < 30)
                    $display("%0t: unexpected median transaction, expected none, got %0d",
                             $time, med_if.median_distance);
            end else begin
                want = median_q.pop_front();
                if (med_if.median_distance !== want) begin
                    fails++;
                    if (fails < 30)
                        $display("%0t: median_distance mismatch, expected %0d, got %0d",
                                 $time, want, med_if.median_distance);
                end
            end
        end
        if (meas_fire) begin
            m.width = meas_if.echo_width;
            m.seen  = meas_if.echo_seen;
            predict_echo(m);
            n_in++;
        end
        if (meas_fire || med_fire || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d medians outstanding", $time, median_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic queue_echo(logic [ECHO_W-1:0] w, logic s);
        t_echo m;
        m.width = w;
        m.seen  = s;
        echo_q.push_back(m);
        n_queued++;
    endtask

    task automatic wait_drained();
        while (n_in != n_queued || median_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic reg_write(logic idx, logic [CFG_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_MIN_ECHO)
            lim_min = value;
        else
            lim_max = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_read_check(logic idx);
        logic [APB_DATA_W-1:0] want;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        want = (idx == REG_MIN_ECHO) ? APB_DATA_W'(lim_min) : APB_DATA_W'(lim_max);
        if (prdata !== want) begin
            fails++;
            $display("%0t: register %0d readback mismatch, expected %0d, got %0d",
                     $time, idx, want, prdata);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_limits(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
        wait_drained();
        reg_write(REG_MIN_ECHO, lo);
        reg_write(REG_MAX_ECHO, hi);
        reg_read_check(REG_MIN_ECHO);
        reg_read_check(REG_MAX_ECHO);
        n_settings++;
    endtask

    function automatic logic [ECHO_W-1:0] pick_width(logic [CFG_W-1:0] lo,
                                                     logic [CFG_W-1:0] hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 45 && lo <= hi) return ECHO_W'($urandom_range(lo, hi));
        if (r < 60) begin
            case ($urandom_range(0, 3))
                0: return lo - 1'b1;
                1: return lo;
                2: return hi;
                default: return hi + 1'b1;
            endcase
        end
        if (r < 70) return ECHO_W'($urandom_range(58700, 65535));
        return ECHO_W'($urandom_range(0, 65535));
    endfunction

    initial begin
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        meas_if.valid      = 1'b0;
        meas_if.echo_width = '0;
        meas_if.echo_seen  = 1'b0;
        med_if.ready       = 1'b0;
        for (int i = 0; i < WIN; i++) win_dist[i] = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset limits, held value still at 999 cm
        reg_read_check(REG_MIN_ECHO);
        reg_read_check(REG_MAX_ECHO);
        queue_echo(16'd0, 1'b1);
        queue_echo(16'd115, 1'b1);
        queue_echo(16'd116, 1'b1);
        queue_echo(16'd117, 1'b1);
        queue_echo(16'd23200, 1'b1);
        queue_echo(16'd23201, 1'b1);
        queue_echo(16'd5000, 1'b0);
        queue_echo(16'd65535, 1'b1);
        queue_echo(16'd1000, 1'b1);
        queue_echo(16'd0, 1'b0);

        // wide open: zero, large and saturating widths
        set_limits(16'd0, 16'd65535);
        queue_echo(16'd0, 1'b1);
        queue_echo(16'd65535, 1'b1);
        queue_echo(16'd58771, 1'b1);
        queue_echo(16'd58772, 1'b1);
        queue_echo(16'd58770, 1'b1);
        queue_echo(16'd29, 1'b1);
        queue_echo(16'd30000, 1'b0);
        queue_echo(16'd65535, 1'b0);

        // crossed limits: nothing accepted
        set_limits(16'd30000, 16'd100);
        queue_echo(16'd50, 1'b1);
        queue_echo(16'd30000, 1'b1);
        queue_echo(16'd100, 1'b1);
        queue_echo(16'd65535, 1'b1);
        queue_echo(16'd0, 1'b1);

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: begin lo = MIN_ECHO_RESET; hi = MAX_ECHO_RESET; end
                1: begin lo = 16'd0;     hi = 16'd0;     end
                2: begin lo = 16'd65535; hi = 16'd65535; end
                3: begin lo = 16'd0;     hi = 16'd65535; end
                4: begin lo = 16'd40000; hi = 16'd20000; end
                default: begin
                    lo = CFG_W'($urandom_range(0, 30000));
                    hi = CFG_W'($urandom_range(lo, 65535));
                end
            endcase
            set_limits(lo, hi);
            if (p % 4 == 1) begin
                in_idle_on  = 1'b0;
                out_idle_on = 1'b0;
            end else begin
                in_idle_on  = $urandom_range(0, 4) != 0;
                out_idle_on = $urandom_range(0, 3) != 0;
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
                queue_echo(pick_width(lo, hi), $urandom_range(0, 9) != 0);
        end

        wait_drained();
        $display("%0d echo transactions sent, %0d medians checked", n_in, n_out);
        $display("%0d limit settings incl. open, closed and crossed ranges", n_settings);
        if (fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ echo_range_median_filter.f @@
hdl/erm_pkg.sv
hdl/erm_if.sv
hdl/erm_dpath.sv
hdl/erm_ctrl.sv
hdl/echo_range_median_filter.sv
test/testbench.sv
